### hdl/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

   localparam int FRAME_DEPTH_DEF     = 64;
   localparam int HOLDING_COUNT_DEF   = 16;
   localparam int INPUT_COUNT_DEF     = 16;
   localparam int RESET_CMD_INDEX_DEF = 9;
   localparam int ERROR_INDEX_DEF     = 8;

   localparam logic [1:0] CMD_BYTE     = 2'd0;
   localparam logic [1:0] CMD_LOAD     = 2'd1;
   localparam logic [1:0] CMD_LINE_ERR = 2'd2;

   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT     = 8'd4;
   localparam logic [7:0] FC_WRITE_SINGLE   = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

   localparam logic [7:0]  EXC_FLAG         = 8'h80;
   localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   typedef struct packed {
      logic take;
      logic drop;
      logic start;
      logic wr_single;
      logic wr_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic ge3;
      logic fc_known;
      logic complete;
      logic frame_ok;
      logic bad;
      logic is_fc6;
      logic is_fc16;
      logic qty_zero;
      logic wr_last;
      logic out_free;
      logic rsp_last;
   } dp_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### hdl/mrs_ctrl.sv
`timescale 1ns / 1ps

module mrs_ctrl import mrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_stall,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SERVE, ST_WR_WAIT, ST_WR_STEP, ST_RESP
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_cmd == CMD_BYTE) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (st.ge3) begin
               if (!st.fc_known) begin
                  cmd.drop = 1'b1;
               end else if (st.complete) begin
                  cmd.drop = 1'b1;
                  if (st.frame_ok) begin
                     state_in = ST_SERVE;
                  end
               end
            end
         end
         ST_SERVE: begin
            cmd.start = 1'b1;
            cmd.wr_single = st.is_fc6 && !st.bad;
            if (st.is_fc16 && !st.bad && !st.qty_zero) begin
               state_in = ST_WR_WAIT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WR_WAIT: begin
            state_in = ST_WR_STEP;
         end
         ST_WR_STEP: begin
            cmd.wr_step = 1'b1;
            state_in = st.wr_last ? ST_RESP : ST_WR_WAIT;
         end
         ST_RESP: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.rsp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mrs_dpath.sv
`timescale 1ns / 1ps

module mrs_dpath import mrs_pkg::*; #(
   parameter int FRAME_DEPTH     = FRAME_DEPTH_DEF,
   parameter int HOLDING_COUNT   = HOLDING_COUNT_DEF,
   parameter int INPUT_COUNT     = INPUT_COUNT_DEF,
   parameter int RESET_CMD_INDEX = RESET_CMD_INDEX_DEF,
   parameter int ERROR_INDEX     = ERROR_INDEX_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_cmd,
   input  logic [7:0]    req_rx_byte,
   input  logic [3:0]    req_reg_index,
   input  logic [15:0]   req_reg_value,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [7:0]    rsp_tx_byte,
   output logic          rsp_tx_last,
   input  dp_cmd_type    cmd,
   output dp_status_type st
);

   localparam int AW   = $clog2(FRAME_DEPTH);
   localparam int MAXC = (HOLDING_COUNT > INPUT_COUNT) ? HOLDING_COUNT : INPUT_COUNT;
   localparam int HAW  = $clog2(HOLDING_COUNT);
   localparam int IAW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int PW   = $clog2(MAXC + 1);
   localparam int KW   = $clog2(2 * MAXC + 5);

   logic [7:0]    frame_mem [FRAME_DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] count_ff;
   logic [AW-1:0] wptr_ff;
   logic [7:0]    hdr_ff [7];
   logic [15:0]   rx_crc_ff;
   logic [15:0]   tx_crc_ff;
   logic [7:0]    hi_ff;
   logic          ph_ff;
   logic [PW-1:0] ptr_ff;
   logic [KW-1:0] k_ff;
   logic [15:0]   holding_ff [HOLDING_COUNT];
   logic [15:0]   input_ff [INPUT_COUNT];
   logic [7:0]    slave_addr_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;

   logic          mem_we;
   logic [7:0]    fc;
   logic [15:0]   addr16;
   logic [15:0]   qty16;
   logic [16:0]   sum17;
   logic [16:0]   qty2;
   logic          is_read;
   logic          bad;
   logic [KW-1:0] len;
   logic [15:0]   regval;
   logic [7:0]    tx_byte;
   logic [AW-1:0] wend;

   assign mem_we = cmd.take && (req_cmd == CMD_BYTE) && (count_ff < AW'(FRAME_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[count_ff] <= req_rx_byte;
      end
      rdata_ff <= frame_mem[wptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.drop) begin
         count_ff <= '0;
      end else if (cmd.take && (req_cmd == CMD_BYTE)) begin
         count_ff <= mem_we ? count_ff + AW'(1) : '0;
      end else if (cmd.take && (req_cmd == CMD_LINE_ERR)) begin
         count_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rx_crc_ff <= crc_byte((count_ff == '0) ? CRC_INIT : rx_crc_ff, req_rx_byte);
         if (count_ff < AW'(7)) begin
            hdr_ff[count_ff[2:0]] <= req_rx_byte;
         end
      end
   end

   assign fc      = hdr_ff[1];
   assign addr16  = {hdr_ff[2], hdr_ff[3]};
   assign qty16   = {hdr_ff[4], hdr_ff[5]};
   assign sum17   = {1'b0, addr16} + {1'b0, qty16};
   assign qty2    = {qty16, 1'b0};
   assign is_read = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
   assign wend    = AW'(17'd6 + qty2);

   always_comb begin
      case (fc)
         FC_READ_HOLDING:  bad = sum17 > 17'(HOLDING_COUNT);
         FC_READ_INPUT:    bad = sum17 > 17'(INPUT_COUNT);
         FC_WRITE_SINGLE:  bad = {1'b0, addr16} >= 17'(HOLDING_COUNT);
         default:          bad = (sum17 > 17'(HOLDING_COUNT)) || ({9'd0, hdr_ff[6]} != qty2);
      endcase
   end

   always_comb begin
      if (bad) begin
         len = KW'(3);
      end else if (is_read) begin
         len = KW'(3) + {qty16[KW-2:0], 1'b0};
      end else begin
         len = KW'(6);
      end
   end

   assign st.ge3      = count_ff >= AW'(3);
   assign st.fc_known = is_read || (fc == FC_WRITE_SINGLE) || (fc == FC_WRITE_MULTIPLE);
   assign st.complete = (fc == FC_WRITE_MULTIPLE)
                        ? ((count_ff >= AW'(7)) &&
                           ({{(10-AW){1'b0}}, count_ff} >= (10'd9 + {2'd0, hdr_ff[6]})))
                        : (count_ff >= AW'(8));
   assign st.frame_ok = (hdr_ff[0] == slave_addr_ff) && (rx_crc_ff == 16'd0);
   assign st.bad      = bad;
   assign st.is_fc6   = (fc == FC_WRITE_SINGLE);
   assign st.is_fc16  = (fc == FC_WRITE_MULTIPLE);
   assign st.qty_zero = (qty16 == 16'd0);
   assign st.wr_last  = (wptr_ff == wend);
   assign st.out_free = !rsp_valid_ff || !rsp_stall;
   assign st.rsp_last = (k_ff == len + KW'(1));

   assign regval = (fc == FC_READ_HOLDING) ? holding_ff[ptr_ff[HAW-1:0]]
                                           : input_ff[ptr_ff[IAW-1:0]];

   always_comb begin
      if (k_ff == len) begin
         tx_byte = tx_crc_ff[7:0];
      end else if (k_ff == len + KW'(1)) begin
         tx_byte = tx_crc_ff[15:8];
      end else begin
         case (k_ff)
            KW'(0):  tx_byte = hdr_ff[0];
            KW'(1):  tx_byte = bad ? (fc | EXC_FLAG) : fc;
            KW'(2):  tx_byte = bad ? EXC_ILLEGAL_ADDR : (is_read ? qty2[7:0] : hdr_ff[2]);
            default: tx_byte = is_read ? (ph_ff ? regval[7:0] : regval[15:8])
                                       : hdr_ff[k_ff[2:0]];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         k_ff      <= '0;
         ph_ff     <= 1'b0;
         ptr_ff    <= PW'(addr16);
         wptr_ff   <= AW'(7);
         tx_crc_ff <= CRC_INIT;
      end else if (cmd.wr_step) begin
         wptr_ff <= wptr_ff + AW'(1);
         ph_ff   <= !ph_ff;
         if (!ph_ff) begin
            hi_ff <= rdata_ff;
         end else begin
            ptr_ff <= ptr_ff + PW'(1);
         end
      end else if (cmd.emit) begin
         k_ff <= k_ff + KW'(1);
         if (k_ff < len) begin
            tx_crc_ff <= crc_byte(tx_crc_ff, tx_byte);
         end
         if (is_read && !bad && (k_ff >= KW'(3)) && (k_ff < len)) begin
            ph_ff <= !ph_ff;
            if (ph_ff) begin
               ptr_ff <= ptr_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOLDING_COUNT; i++) begin
            holding_ff[i] <= '0;
         end
      end else if (cmd.wr_single) begin
         holding_ff[addr16[HAW-1:0]] <= qty16;
         if ((addr16 == 16'(RESET_CMD_INDEX)) && (qty16 == 16'd1) &&
             (ERROR_INDEX < HOLDING_COUNT)) begin
            holding_ff[HAW'(ERROR_INDEX)] <= '0;
         end
      end else if (cmd.wr_step && ph_ff) begin
         holding_ff[ptr_ff[HAW-1:0]] <= {hi_ff, rdata_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < INPUT_COUNT; i++) begin
            input_ff[i] <= '0;
         end
      end else if (cmd.take && (req_cmd == CMD_LOAD) &&
                   ({28'd0, req_reg_index} < 32'(INPUT_COUNT))) begin
         input_ff[IAW'(req_reg_index)] <= req_reg_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 8'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         slave_addr_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {24'd0, slave_addr_ff};
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= tx_byte;
         rsp_last_ff <= st.rsp_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_byte_ff;
   assign rsp_tx_last = rsp_last_ff;

endmodule

### hdl/modbus_rtu_slave_engine.sv
`timescale 1ns / 1ps
// Modbus RTU slave. Each request carries a command: a received byte, a load of
// one input register, or a line error that drops the frame under reception.
// Received bytes go into a frame memory while a CRC-16 is kept per byte; the
// function code decides when a frame is complete.
// A request is accepted in the idle state; a received byte then goes to the
// check state, which ends it unless it completes a frame. A complete frame with
// a good address and CRC passes a serve state, then, for a write-multiple, a
// wait and a write step per data byte (one memory read port), then one response
// byte per cycle while not stalled; a response is 5 to 2*N+5 bytes.
// The request side is stalled from acceptance of a byte until its work ends.
// Responses leave through an output register; the next request is accepted
// while the last response byte waits there. When the receiver stalls, the
// held byte stays unchanged and the sequencer waits.
// The station address is written through the APB-style port at address 0.
// Reset empties the frame, clears all holding and input registers, and sets
// the station address to 1. No clearing pass is needed.
module modbus_rtu_slave_engine import mrs_pkg::*; #(
   parameter int FRAME_DEPTH     = FRAME_DEPTH_DEF,
   parameter int HOLDING_COUNT   = HOLDING_COUNT_DEF,
   parameter int INPUT_COUNT     = INPUT_COUNT_DEF,
   parameter int RESET_CMD_INDEX = RESET_CMD_INDEX_DEF,
   parameter int ERROR_INDEX     = ERROR_INDEX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic [3:0]  req_reg_index,
   input  logic [15:0] req_reg_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dp_cmd_type    cmd;
   dp_status_type st;

   mrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   mrs_dpath #(
      .FRAME_DEPTH     (FRAME_DEPTH),
      .HOLDING_COUNT   (HOLDING_COUNT),
      .INPUT_COUNT     (INPUT_COUNT),
      .RESET_CMD_INDEX (RESET_CMD_INDEX),
      .ERROR_INDEX     (ERROR_INDEX)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_rx_byte   (req_rx_byte),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_tx_last   (rsp_tx_last),
      .cmd           (cmd),
      .st            (st)
   );

endmodule

### hdl/mrs_checker.sv
`timescale 1ns / 1ps

module mrs_checker import mrs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_tx_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_tx_last)))
      else $error("stalled response byte changed");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_cmd == CMD_BYTE)) |=> req_stall)
      else $error("received byte not followed by a busy cycle");

   a_first_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("response started while requests were open");

endmodule

bind modbus_rtu_slave_engine mrs_checker u_mrs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_cmd     (req_cmd),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_tx_last (rsp_tx_last)
);

### tb/sv/modbus_rtu_slave_engine_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_slave_engine_tb;
   import mrs_pkg::*;

   localparam int FDEPTH = FRAME_DEPTH_DEF;
   localparam int NHOLD  = HOLDING_COUNT_DEF;
   localparam int NINPUT = INPUT_COUNT_DEF;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } reply_byte_type;

   class reply_scoreboard;
      reply_byte_type pending[$];
      int          errors;
      int          replies;
      logic [7:0]  station;
      logic [7:0]  frame[FDEPTH];
      int          count;
      logic [15:0] holding[NHOLD];
      logic [15:0] inputs[NINPUT];

      function new();
         errors = 0;
         replies = 0;
         station = 8'd1;
         count = 0;
         foreach (holding[i]) holding[i] = '0;
         foreach (inputs[i]) inputs[i] = '0;
      endfunction

      function logic [15:0] crc16(logic [7:0] b[$]);
         logic [15:0] c;
         c = 16'hFFFF;
         foreach (b[k]) begin
            c ^= {8'h00, b[k]};
            for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
         return c;
      endfunction

      function void answer_frame();
         logic [7:0]  tx[$];
         logic [7:0]  body[$];
         logic [7:0]  fc;
         logic [15:0] c, v;
         int          n, addr, qty, cnt;
         logic        bad;
         n = count;
         count = 0;
         bad = 1'b0;
         if (n < 8 || frame[0] != station) return;
         for (int k = 0; k < n - 2; k++) body.push_back(frame[k]);
         c = crc16(body);
         if (frame[n-2] != c[7:0] || frame[n-1] != c[15:8]) return;
         fc = frame[1];
         addr = {frame[2], frame[3]};
         qty = {frame[4], frame[5]};
         tx.push_back(station);
         tx.push_back(fc);
         if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
            if (addr + qty <= ((fc == FC_READ_HOLDING) ? NHOLD : NINPUT)) begin
               tx.push_back(8'(qty * 2));
               for (int i = 0; i < qty; i++) begin
                  v = (fc == FC_READ_HOLDING) ? holding[addr+i] : inputs[addr+i];
                  tx.push_back(v[15:8]);
                  tx.push_back(v[7:0]);
               end
            end else bad = 1'b1;
         end else if (fc == FC_WRITE_SINGLE) begin
            if (addr < NHOLD) begin
               holding[addr] = qty[15:0];
               if (addr == RESET_CMD_INDEX_DEF && qty == 1 && ERROR_INDEX_DEF < NHOLD)
                  holding[ERROR_INDEX_DEF] = '0;
               for (int k = 2; k < 6; k++) tx.push_back(frame[k]);
            end else bad = 1'b1;
         end else begin
            cnt = frame[6];
            if (addr + qty <= NHOLD && cnt == qty * 2 && n >= 9 + cnt) begin
               for (int i = 0; i < qty; i++) holding[addr+i] = {frame[7+2*i], frame[8+2*i]};
               for (int k = 2; k < 6; k++) tx.push_back(frame[k]);
            end else bad = 1'b1;
         end
         if (bad) begin
            tx.delete();
            tx.push_back(station);
            tx.push_back(fc | EXC_FLAG);
            tx.push_back(EXC_ILLEGAL_ADDR);
         end
         c = crc16(tx);
         tx.push_back(c[7:0]);
         tx.push_back(c[15:8]);
         foreach (tx[k]) pending.push_back('{tx[k], k == tx.size() - 1});
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] rxb, logic [3:0] idx,
                                 logic [15:0] val);
         int need;
         need = 0;
         if (cmd == CMD_LOAD) begin
            if (idx < NINPUT) inputs[idx] = val;
            return;
         end
         if (cmd == CMD_LINE_ERR) begin
            count = 0;
            return;
         end
         if (cmd != CMD_BYTE) return;
         if (count >= FDEPTH - 1) begin
            count = 0;
            return;
         end
         frame[count] = rxb;
         count++;
         if (count < 3) return;
         case (frame[1])
            FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_SINGLE: need = 8;
            FC_WRITE_MULTIPLE: if (count >= 7) need = 9 + frame[6];
            default: begin
               count = 0;
               return;
            end
         endcase
         if (need > 0 && count >= need) answer_frame();
      endfunction

      function void check_reply(logic [7:0] b, logic last);
         reply_byte_type e;
         replies++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply byte %h last %b", $time, b, last);
            return;
         end
         e = pending.pop_front();
         if (e.tx_byte !== b) begin
            errors++;
            $display("%0t: tx_byte expected %h actual %h", $time, e.tx_byte, b);
         end
         if (e.tx_last !== last) begin
            errors++;
            $display("%0t: tx_last expected %b actual %b", $time, e.tx_last, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [7:0]  req_rx_byte = '0;
   logic [3:0]  req_reg_index = '0;
   logic [15:0] req_reg_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   reply_scoreboard board;
   int  requests_sent = 0;
   int  hold_off_cycles = 0;
   bit  stall_enable = 1'b0;

   modbus_rtu_slave_engine dut (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("modbus_rtu_slave_engine_tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_reply(rsp_tx_byte, rsp_tx_last);
   end

   // Receiver stall pattern; a long hold-off is requested through hold_off_cycles.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         gap = stall_enable ? $urandom_range(0, 14) : 0;
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [3:0] idx = '0,
                               logic [15:0] val = '0, bit idle = 1'b1);
      int gap;
      gap = (idle && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_rx_byte <= b;
      req_reg_index <= idx;
      req_reg_value <= val;
      @(posedge clock iff !req_stall);
      board.note_request(cmd, b, idx, val);
      requests_sent++;
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic send_frame(logic [7:0] bytes[$], bit good_crc = 1'b1, bit idle = 1'b1);
      logic [15:0] c;
      c = board.crc16(bytes);
      if (!good_crc) c ^= 16'h0001 << $urandom_range(0, 15);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      foreach (bytes[k]) send_request(CMD_BYTE, bytes[k], '0, '0, idle);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      stop_requests();
      while (board.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic write_station(logic [7:0] a);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {24'h0, a};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.station = a;
   endtask

   task automatic random_frame(bit idle);
      logic [7:0] f[$];
      logic [7:0] fc;
      int r, addr, qty, cnt;
      r = $urandom_range(0, 9);
      fc = (r < 3) ? FC_READ_HOLDING : (r < 5) ? FC_READ_INPUT :
           (r < 7) ? FC_WRITE_SINGLE : FC_WRITE_MULTIPLE;
      addr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 17);
      qty = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
      f.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : board.station);
      f.push_back(fc);
      f.push_back(addr[15:8]);
      f.push_back(addr[7:0]);
      if (fc == FC_WRITE_SINGLE && $urandom_range(0, 3) == 0) qty = ($urandom_range(0, 1) ? 1 : $urandom);
      if (fc == FC_WRITE_SINGLE && $urandom_range(0, 3) == 0) addr = RESET_CMD_INDEX_DEF;
      f[2] = addr[15:8];
      f[3] = addr[7:0];
      f.push_back(qty[15:8]);
      f.push_back(qty[7:0]);
      if (fc == FC_WRITE_MULTIPLE) begin
         cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : 2 * qty[7:0] % 256;
         if (cnt > 24) cnt = 4;
         f.push_back(8'(cnt));
         repeat (cnt) f.push_back(8'($urandom));
      end
      send_frame(f, $urandom_range(0, 9) != 0, idle);
   endtask

   initial begin
      logic [7:0] f[$];
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_enable = 1'b1;

      // Directed part.
      send_request(CMD_LOAD, '0, 4'd0, 16'hFFFF);
      send_request(CMD_LOAD, '0, 4'd15, 16'h0000);
      send_request(CMD_LOAD, '0, 4'd5, 16'hA5C3);
      send_request(CMD_UNUSED, 8'hFF, 4'hF, 16'hFFFF);
      send_frame('{8'd1, FC_READ_INPUT, 8'd0, 8'd0, 8'd0, 8'd16});
      send_frame('{8'd1, FC_WRITE_SINGLE, 8'd0, 8'd8, 8'hBE, 8'hEF});
      send_frame('{8'd1, FC_WRITE_SINGLE, 8'd0, 8'd9, 8'd0, 8'd1});
      send_frame('{8'd1, FC_WRITE_SINGLE, 8'd0, 8'd16, 8'd0, 8'd1});
      send_frame('{8'd1, FC_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd0});
      send_frame('{8'd1, FC_READ_HOLDING, 8'd0, 8'd15, 8'd0, 8'd2});
      send_frame('{8'd1, FC_WRITE_MULTIPLE, 8'd0, 8'd2, 8'd0, 8'd2, 8'd4,
                   8'h12, 8'h34, 8'h56, 8'h78});
      send_frame('{8'd1, FC_WRITE_MULTIPLE, 8'd0, 8'd2, 8'd0, 8'd2, 8'd3,
                   8'h12, 8'h34, 8'h56});
      send_frame('{8'd2, FC_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1});
      send_frame('{8'd1, FC_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0);
      send_request(CMD_BYTE, 8'd1);
      send_request(CMD_BYTE, 8'd7);
      send_request(CMD_BYTE, 8'd0);
      send_request(CMD_BYTE, 8'd1);
      send_request(CMD_LINE_ERR, '0);
      f = '{8'd1, FC_WRITE_MULTIPLE, 8'd0, 8'd0, 8'd0, 8'd30, 8'd255};
      repeat (60) f.push_back(8'($urandom));
      foreach (f[k]) send_request(CMD_BYTE, f[k], '0, '0, 1'b0);
      drain();

      write_station(8'd247);
      send_frame('{8'd247, FC_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd16});
      drain();

      // Receiver holds off while requests keep coming.
      hold_off_cycles = 400;
      repeat (3) random_frame(1'b0);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         write_station(phase == 0 ? 8'd1 : 8'($urandom_range(1, 247)));
         while (requests_sent < 215 + 15 * (phase + 1)) begin
            case ($urandom_range(0, 9))
               0: send_request(CMD_LOAD, '0, 4'($urandom), 16'($urandom));
               1: send_request(CMD_LINE_ERR, 8'($urandom));
               2: send_request(CMD_BYTE, 8'($urandom));
               3: send_request(CMD_UNUSED, 8'($urandom));
               default: random_frame($urandom_range(0, 3) != 0);
            endcase
            if ($urandom_range(0, 15) == 0) drain();
         end
         drain();
      end

      $display("Covered %0d requests and %0d reply bytes over several station addresses,",
               requests_sent, board.replies);
      $display("including exceptions, bad CRC, foreign address, overflow and line errors.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("modbus_rtu_slave_engine_tb OK");
      end else begin
         $display("modbus_rtu_slave_engine_tb NOT OK");
      end
      $finish;
   end
endmodule
